>>> src/rbsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg: shared constants and types for the ray/box slab test.
// Holds default parameter values, the register count, the register index
// width and the register index enum.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int DEF_WORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int NUM_REGS       = 6;
    localparam int REG_IDX_W      = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } reg_idx_t;

endpackage : rbsi_pkg
`default_nettype wire

>>> src/rbsi_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_div_cell: one restoring-division step for six lanes.
// Each cell retires one quotient bit per lane and passes the partial
// remainder, quotient and operands on to its right-hand neighbor.
// ----------------------------------------------------------------------------
module rbsi_div_cell
    import rbsi_pkg::*;
#(
    parameter int MAG_W = 32,
    parameter int Q_W   = 49,
    parameter int NUM_W = 48
)
(
    input  wire logic             clk,
    input  wire logic [6*MAG_W-1:0] dmag_in,
    input  wire logic [6*MAG_W-1:0] rem_in,
    input  wire logic [6*Q_W-1:0]   q_in,
    input  wire logic [6*NUM_W-1:0] num_in,
    output logic      [6*MAG_W-1:0] dmag_out,
    output logic      [6*MAG_W-1:0] rem_out,
    output logic      [6*Q_W-1:0]   q_out,
    output logic      [6*NUM_W-1:0] num_out
);

    logic [6*MAG_W-1:0] rem_next;
    logic [6*Q_W-1:0]   q_next;
    logic [6*NUM_W-1:0] num_next;

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            logic [MAG_W:0] trial;
            logic [MAG_W:0] dm;
            trial = {rem_in[l*MAG_W +: MAG_W], num_in[l*NUM_W + NUM_W - 1]};
            dm = {1'b0, dmag_in[l*MAG_W +: MAG_W]};
            if (trial >= dm)
            begin
                trial = trial - dm;
                q_next[l*Q_W +: Q_W] = {q_in[l*Q_W +: Q_W-1], 1'b1};
            end
            else
            begin
                q_next[l*Q_W +: Q_W] = {q_in[l*Q_W +: Q_W-1], 1'b0};
            end
            // The remainder stays below the divisor, so its top bit drops.
            rem_next[l*MAG_W +: MAG_W] = trial[MAG_W-1:0];
            num_next[l*NUM_W +: NUM_W] = {num_in[l*NUM_W +: NUM_W-1], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_out <= dmag_in;
        rem_out  <= rem_next;
        q_out    <= q_next;
        num_out  <= num_next;
    end

endmodule : rbsi_div_cell
`default_nettype wire

>>> src/ray_box_slab_intersect_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_core: ray versus axis-aligned box slab test.
// Six pipelined fixed-point dividers built as a chain of one-bit cells,
// followed by interval ordering, intersection and window clipping.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Transfer when
//  -------   ------------------------------   ---------------------------
//  command   start, busy, box_*, window_*     start && !busy
//  result    done, hit, clipped_near/far      done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_*      cfg_valid && cfg_ready
//
// One box test is taken every cycle; busy is never raised. The path is an
// input stage, the division chain (one cell per quotient bit, WORD_WIDTH +
// FRAC_BITS + 1 cells) and two output stages. Reset (rst_n, asynchronous,
// low) clears only the pipeline valid bits and restores the ray registers.
// The receiver cannot stall, so results simply leave on done.
//
module ray_box_slab_intersect_core
    import rbsi_pkg::*;
#(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [WORD_WIDTH-1:0] box_min_x,
    input  wire logic signed [WORD_WIDTH-1:0] box_min_y,
    input  wire logic signed [WORD_WIDTH-1:0] box_min_z,
    input  wire logic signed [WORD_WIDTH-1:0] box_max_x,
    input  wire logic signed [WORD_WIDTH-1:0] box_max_y,
    input  wire logic signed [WORD_WIDTH-1:0] box_max_z,
    input  wire logic signed [WORD_WIDTH-1:0] window_near,
    input  wire logic signed [WORD_WIDTH-1:0] window_far,
    output logic                              done,
    output logic                              hit,
    output logic signed [WORD_WIDTH-1:0]      clipped_near,
    output logic signed [WORD_WIDTH-1:0]      clipped_far,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [REG_IDX_W-1:0]         cfg_index,
    input  wire logic [WORD_WIDTH-1:0]        cfg_data
);

    localparam int W     = WORD_WIDTH;
    // A difference of two W-bit values needs W+1 bits of magnitude.
    localparam int MAG_W = W + 1;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    // Quotient bits kept: enough to see anything beyond the saturation limit.
    localparam int Q_W   = NUM_W;
    localparam int DEPTH = NUM_W;

    localparam logic signed [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

    // Side information that rides along the chain with each item.
    typedef struct packed {
        logic         valid;
        logic [5:0]   neg;
        logic [2:0]   zero_dir;
        logic         zero_miss;
        logic [W-1:0] near;
        logic [W-1:0] far;
    } side_t;

    // ---------------- configuration registers ----------------
    logic signed [W-1:0] org_reg [3];
    logic signed [W-1:0] dir_reg [3];

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // The ray points along +x with unit length after reset.
            for (int a = 0; a < 3; a++)
            begin
                org_reg[a] <= '0;
                dir_reg[a] <= (a == 0) ? (W'(1) << FRAC_BITS) : '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_data;
                REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                REG_DIR_X:    dir_reg[0] <= cfg_data;
                REG_DIR_Y:    dir_reg[1] <= cfg_data;
                REG_DIR_Z:    dir_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ---------------- input stage: magnitudes and signs ----------------
    logic signed [W-1:0] corner [6];
    assign corner[0] = box_min_x;
    assign corner[1] = box_max_x;
    assign corner[2] = box_min_y;
    assign corner[3] = box_max_y;
    assign corner[4] = box_min_z;
    assign corner[5] = box_max_z;

    logic [6*MAG_W-1:0] dmag_s0;
    logic [6*NUM_W-1:0] num_s0;
    side_t              side_s0;

    always_comb
    begin
        side_s0.valid     = start && !busy;
        side_s0.zero_miss = 1'b0;
        for (int l = 0; l < 6; l++)
        begin
            logic signed [W:0] diff;
            logic signed [W:0] dx;
            logic [MAG_W-1:0]  nm;
            logic [MAG_W-1:0]  dm;
            diff = {corner[l][W-1], corner[l]} - {org_reg[l/2][W-1], org_reg[l/2]};
            dx   = {dir_reg[l/2][W-1], dir_reg[l/2]};
            nm   = diff[W] ? MAG_W'(-diff) : MAG_W'(diff);
            dm   = dx[W] ? MAG_W'(-dx) : MAG_W'(dx);
            num_s0[l*NUM_W +: NUM_W] = {nm, {FRAC_BITS{1'b0}}};
            dmag_s0[l*MAG_W +: MAG_W] = dm;
            side_s0.neg[l] = diff[W] ^ dx[W];
        end
        for (int a = 0; a < 3; a++)
        begin
            logic signed [W-1:0] lo;
            logic signed [W-1:0] hi;
            side_s0.zero_dir[a] = (dir_reg[a] == '0);
            lo = (corner[2*a] < corner[2*a+1]) ? corner[2*a] : corner[2*a+1];
            hi = (corner[2*a] < corner[2*a+1]) ? corner[2*a+1] : corner[2*a];
            if (side_s0.zero_dir[a] && (org_reg[a] < lo || org_reg[a] > hi))
            begin
                side_s0.zero_miss = 1'b1;
            end
        end
        if ($signed(window_far) < $signed(window_near))
        begin
            side_s0.near = window_far;
            side_s0.far  = window_near;
        end
        else
        begin
            side_s0.near = window_near;
            side_s0.far  = window_far;
        end
    end

    logic [6*MAG_W-1:0] dmag_c [DEPTH+1];
    logic [6*MAG_W-1:0] rem_c  [DEPTH+1];
    logic [6*Q_W-1:0]   q_c    [DEPTH+1];
    logic [6*NUM_W-1:0] num_c  [DEPTH+1];
    side_t              side_c [DEPTH+1];
    logic               vld_reg [DEPTH+1];

    always_ff @(posedge clk)
    begin
        dmag_c[0] <= dmag_s0;
        num_c[0]  <= num_s0;
        rem_c[0]  <= '0;
        q_c[0]    <= '0;
        side_c[0] <= side_s0;
    end

    // ---------------- division chain ----------------
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        rbsi_div_cell #(.MAG_W(MAG_W), .Q_W(Q_W), .NUM_W(NUM_W)) u_cell
        (
            .clk      (clk),
            .dmag_in  (dmag_c[k]),
            .rem_in   (rem_c[k]),
            .q_in     (q_c[k]),
            .num_in   (num_c[k]),
            .dmag_out (dmag_c[k+1]),
            .rem_out  (rem_c[k+1]),
            .q_out    (q_c[k+1]),
            .num_out  (num_c[k+1])
        );
        always_ff @(posedge clk)
        begin
            side_c[k+1] <= side_c[k];
        end
    end

    // Valid bits follow the payload and are the only reset control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DEPTH; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= side_s0.valid;
            for (int k = 0; k < DEPTH; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    // ---------------- saturate and order per axis ----------------
    logic signed [W-1:0] ent_reg [3];
    logic signed [W-1:0] ext_reg [3];
    side_t               side_t_reg;
    logic                vld_t_reg;

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [W-1:0] t [2];
            for (int s = 0; s < 2; s++)
            begin
                logic [Q_W-1:0] q;
                q = q_c[DEPTH][(2*a+s)*Q_W +: Q_W];
                if (side_c[DEPTH].neg[2*a+s])
                begin
                    t[s] = (q > Q_W'(POS_LIM) + Q_W'(1)) ? NEG_LIM : W'(-q);
                end
                else
                begin
                    t[s] = (q > Q_W'(POS_LIM)) ? POS_LIM : W'(q);
                end
            end
            if (side_c[DEPTH].zero_dir[a])
            begin
                ent_reg[a] <= NEG_LIM;
                ext_reg[a] <= POS_LIM;
            end
            else
            begin
                ent_reg[a] <= (t[0] < t[1]) ? t[0] : t[1];
                ext_reg[a] <= (t[0] < t[1]) ? t[1] : t[0];
            end
        end
        side_t_reg <= side_c[DEPTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_t_reg <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            vld_t_reg <= vld_reg[DEPTH];
            done      <= vld_t_reg;
        end
    end

    // ---------------- intersect and clip ----------------
    always_ff @(posedge clk)
    begin
        logic signed [W-1:0] tmin;
        logic signed [W-1:0] tmax;
        logic signed [W-1:0] nr;
        logic signed [W-1:0] fr;
        tmin = ent_reg[0];
        tmax = ext_reg[0];
        for (int a = 1; a < 3; a++)
        begin
            tmin = (ent_reg[a] > tmin) ? ent_reg[a] : tmin;
            tmax = (ext_reg[a] < tmax) ? ext_reg[a] : tmax;
        end
        nr = side_t_reg.near;
        fr = side_t_reg.far;
        if (!side_t_reg.zero_miss && !(tmax < tmin) && !(tmax < nr) && !(fr < tmin))
        begin
            hit          <= 1'b1;
            clipped_near <= (tmin > nr) ? tmin : nr;
            clipped_far  <= (tmax < fr) ? tmax : fr;
        end
        else
        begin
            hit          <= 1'b0;
            clipped_near <= nr;
            clipped_far  <= fr;
        end
    end

    // ---------------- assertions ----------------
    // A hit never reports an inverted window.
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (clipped_near <= clipped_far))
        else $error("hit with near above far");

    // A miss always reports an ordered window as well.
    a_miss_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (clipped_near <= clipped_far))
        else $error("miss with unordered window");

    // Every accepted command later produces a result on done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(DEPTH+3) done)
        else $error("result did not appear after pipeline latency");

endmodule : ray_box_slab_intersect_core
`default_nettype wire
